@@ src/bounded_deque_with_dump_assert.svh @@
// Assertion macros for the deque block.
`ifndef BOUNDED_DEQUE_WITH_DUMP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_DUMP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define BDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BDQ_ASSERT(lbl, prop)
`define BDQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/bdq_pkg.sv @@
package bdq_pkg;

  localparam int unsigned OpW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OpW-1:0] OP_DUMP       = 3'd4;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_DUMP
  } state_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

  typedef struct packed {
    logic    strobe;
    logic    from_mem;
    logic    last;
    status_e status;
  } res_t;

endpackage

@@ src/bdq_ram.sv @@
module bdq_ram #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk_i,
  input  bdq_pkg::mem_cmd_t               cmd_i,
  input  logic [$clog2(DEPTH)-1:0]        waddr_i,
  input  logic signed [bdq_pkg::DataW-1:0] wdata_i,
  input  logic [$clog2(DEPTH)-1:0]        raddr_i,
  output logic signed [bdq_pkg::DataW-1:0] rdata_o
);

  logic signed [bdq_pkg::DataW-1:0] mem_q [DEPTH];
  logic signed [bdq_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bdq_ctrl.sv @@
module bdq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic [bdq_pkg::OpW-1:0]          opcode_i,
  output logic                             busy,
  output logic [$clog2(DEPTH+1)-1:0]       count_o,
  output bdq_pkg::mem_cmd_t                cmd_o,
  output logic [$clog2(DEPTH)-1:0]         waddr_o,
  output logic [$clog2(DEPTH)-1:0]         raddr_o,
  output bdq_pkg::res_t                    res_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bdq_pkg::state_e state_q, state_d;
  logic [PW-1:0]   front_q, front_d;
  logic [CW-1:0]   count_q, count_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   rem_q, rem_d;
  bdq_pkg::res_t   res_q, res_d;

  logic          full;
  logic          empty;
  logic [PW:0]   back_sum;
  logic [PW-1:0] back_addr;
  logic [PW-1:0] front_dec;
  logic [PW-1:0] rd_ptr_inc;
  logic [PW-1:0] front_inc;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign back_sum   = {1'b0, front_q} + (PW+1)'(count_q);
  assign back_addr  = (back_sum >= (PW+1)'(DEPTH)) ? PW'(back_sum - (PW+1)'(DEPTH))
                                                   : back_sum[PW-1:0];
  assign front_dec  = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
  assign front_inc  = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);
  assign rd_ptr_inc = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bdq_pkg::FSM_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      rd_ptr_q <= '0;
      rem_q    <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      rem_q    <= rem_d;
      res_q    <= res_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    front_d        = front_q;
    count_d        = count_q;
    rd_ptr_d       = rd_ptr_q;
    rem_d          = rem_q;
    res_d          = '0;
    res_d.last     = 1'b1;
    res_d.status   = bdq_pkg::ST_DONE;
    cmd_o          = '0;
    waddr_o        = back_addr;
    raddr_o        = rd_ptr_q;
    unique case (state_q)
      bdq_pkg::FSM_IDLE: begin
        if (start) begin
          res_d.strobe = 1'b1;
          unique case (opcode_i)
            bdq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res_d.status = bdq_pkg::ST_FULL;
              end else begin
                cmd_o.we = 1'b1;
                count_d  = count_q + CW'(1);
              end
            end
            bdq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res_d.status = bdq_pkg::ST_FULL;
              end else begin
                cmd_o.we = 1'b1;
                waddr_o  = front_dec;
                front_d  = front_dec;
                count_d  = count_q + CW'(1);
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              if (empty) begin
                res_d.status = bdq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              if (empty) begin
                res_d.status = bdq_pkg::ST_EMPTY;
              end else begin
                front_d = front_inc;
                count_d = count_q - CW'(1);
              end
            end
            bdq_pkg::OP_DUMP: begin
              if (!empty) begin
                res_d.strobe = 1'b0;
                state_d      = bdq_pkg::FSM_DUMP;
                rd_ptr_d     = front_q;
                rem_d        = count_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bdq_pkg::FSM_DUMP: begin
        cmd_o.re       = 1'b1;
        res_d.strobe   = 1'b1;
        res_d.from_mem = 1'b1;
        res_d.last     = (rem_q == CW'(1));
        rd_ptr_d       = rd_ptr_inc;
        rem_d          = rem_q - CW'(1);
        if (rem_q == CW'(1)) begin
          state_d = bdq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = bdq_pkg::FSM_IDLE;
      end
    endcase
  end

  assign busy    = (state_q == bdq_pkg::FSM_DUMP);
  assign count_o = count_q;
  assign res_o   = res_q;

endmodule

@@ src/bounded_deque_with_dump.sv @@
// Bounded double-ended queue of signed 32-bit values kept in a ring memory.
// An item is taken at a rising edge where start is high and busy is low; it
// carries opcode_i (push back, push front, pop back, pop front, dump) and
// value_i, which only pushes use.
// Results appear on element_o, element_valid_o, last_o, count_o and status_o
// for exactly one cycle, marked by strobe_o. The receiver cannot stall them.
// Push, pop and unused opcodes give one result in the cycle after the item is
// taken, and busy stays low, so such items go one per cycle. A push onto a
// full queue or a pop from an empty one leaves the queue alone and reports it
// in status_o.
// A dump of N stored elements raises busy while the memory read port walks
// from front to back; one result per element follows, each shown in the cycle
// after its read, last_o marking the tail. A dump of an empty queue gives one
// result with element_valid_o low. The next item may be taken in the cycle in
// which the final dump result is shown.
// Reset empties the queue at once; memory contents are not cleared.
module bounded_deque_with_dump #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [bdq_pkg::OpW-1:0]           opcode_i,
  input  logic signed [bdq_pkg::DataW-1:0]  value_i,
  output logic                              strobe_o,
  output logic signed [bdq_pkg::DataW-1:0]  element_o,
  output logic                              element_valid_o,
  output logic                              last_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o,
  output logic [1:0]                        status_o
);

  `include "bounded_deque_with_dump_assert.svh"

  localparam int unsigned PW = $clog2(DEPTH);

  bdq_pkg::mem_cmd_t                 cmd;
  bdq_pkg::res_t                     res;
  logic [PW-1:0]                     waddr;
  logic [PW-1:0]                     raddr;
  logic signed [bdq_pkg::DataW-1:0]  rdata;

  bdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .opcode_i(opcode_i),
    .busy    (busy),
    .count_o (count_o),
    .cmd_o   (cmd),
    .waddr_o (waddr),
    .raddr_o (raddr),
    .res_o   (res)
  );

  bdq_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign strobe_o        = res.strobe;
  assign element_o       = res.from_mem ? rdata : '0;
  assign element_valid_o = res.from_mem;
  assign last_o          = res.last;
  assign status_o        = res.status;

  `BDQ_ASSERT(count_in_range, count_o <= ($clog2(DEPTH+1))'(DEPTH))
  `BDQ_ASSERT_NEXT(accept_answered, start && !busy, strobe_o || busy)
  `BDQ_ASSERT(last_ends_busy, (strobe_o && last_o) |-> !busy)
  `BDQ_ASSERT(no_write_in_dump, busy |-> !cmd.we)

endmodule

@@ test/tb_bounded_deque_with_dump.sv @@
import bdq_pkg::*;

localparam int QDEPTH = 16;
localparam logic [OpW-1:0] OP_NOP_FIRST = 3'd5;
localparam logic [OpW-1:0] OP_NOP_LAST = 3'd7;

typedef struct {
  logic signed [DataW-1:0] element;
  logic valid;
  logic last;
  logic [4:0] count;
  status_e status;
} deque_result_t;

class deque_scoreboard;
  logic signed [DataW-1:0] ring[QDEPTH];
  logic [3:0] head;
  logic [4:0] fill;
  deque_result_t awaited[$];
  int errors;

  function new();
    head = '0;
    fill = '0;
    errors = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // Applies one accepted item to the shadow deque and queues the results it causes.
  function void note_item(logic [OpW-1:0] op, logic signed [DataW-1:0] val);
    deque_result_t res;
    logic [3:0] slot;
    res.element = '0;
    res.valid = 1'b0;
    res.last = 1'b1;
    res.status = ST_DONE;
    case (op)
      OP_PUSH_BACK: begin
        if (fill >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = head + fill[3:0];
          ring[slot] = val;
          fill = fill + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (fill >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          head = head - 1'b1;
          ring[head] = val;
          fill = fill + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (fill == 0) res.status = ST_EMPTY;
        else fill = fill - 1'b1;
      end
      OP_POP_FRONT: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          head = head + 1'b1;
          fill = fill - 1'b1;
        end
      end
      OP_DUMP: begin
        if (fill != 0) begin
          for (int k = 0; k < fill; k++) begin
            slot = head + k[3:0];
            res.element = ring[slot];
            res.valid = 1'b1;
            res.last = (k == fill - 1);
            res.count = fill;
            awaited.insert(awaited.size(), res);
          end
          return;
        end
      end
      default: begin
      end
    endcase
    res.count = fill;
    awaited.insert(awaited.size(), res);
  endfunction

  function void report(string field, longint expected, longint actual);
    if (expected != actual) begin
      $display("%0t: %s expected %0d got %0d", $time, field, expected, actual);
      errors++;
    end
  endfunction

  function void check_result(logic signed [DataW-1:0] element, logic valid, logic last,
                             logic [4:0] count, logic [1:0] status);
    deque_result_t res;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result expected none got element %0d count %0d", $time,
               element, count);
      errors++;
      return;
    end
    res = awaited[0];
    awaited.delete(0);
    report("element", res.element, element);
    report("element_valid", res.valid, valid);
    report("last", res.last, last);
    report("count", res.count, count);
    report("status", res.status, status);
  endfunction
endclass

module tb_bounded_deque_with_dump;

  localparam int STALL_LIMIT = 400;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [OpW-1:0] opcode_i;
  logic signed [DataW-1:0] value_i;
  logic strobe_o;
  logic signed [DataW-1:0] element_o;
  logic element_valid_o;
  logic last_o;
  logic [4:0] count_o;
  logic [1:0] status_o;

  deque_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;

  bounded_deque_with_dump #(
    .DEPTH(QDEPTH)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .opcode_i(opcode_i),
    .value_i(value_i),
    .strobe_o(strobe_o),
    .element_o(element_o),
    .element_valid_o(element_valid_o),
    .last_o(last_o),
    .count_o(count_o),
    .status_o(status_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_result(element_o, element_valid_o, last_o, count_o, status_o);
    end
    if ((start && !busy) || strobe_o) idle_cycles = 0;
    else idle_cycles++;
    if (rst_ni && idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sends one item, inserting a random gap whenever the current burst is used up.
  task automatic issue(input logic [OpW-1:0] op, input logic signed [DataW-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    opcode_i <= op;
    value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(op, val);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int r;
    int phase_left;
    bit filling;
    logic [OpW-1:0] op;
    logic signed [DataW-1:0] val;

    rst_ni <= 1'b0;
    start <= 1'b0;
    opcode_i <= OP_PUSH_BACK;
    value_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(OP_DUMP, 32'sd0);
    issue(OP_POP_BACK, 32'sd0);
    issue(OP_POP_FRONT, -32'sd1);
    issue(OP_NOP_FIRST, 32'sd5);
    issue(OP_NOP_LAST, 32'sd7);
    issue(OP_PUSH_BACK, 32'sh7fffffff);
    issue(OP_PUSH_FRONT, 32'sh80000000);
    issue(OP_PUSH_BACK, 32'sd0);
    issue(OP_PUSH_FRONT, -32'sd1);
    issue(OP_DUMP, 32'sd0);
    issue(OP_POP_BACK, 32'sd0);
    issue(OP_POP_FRONT, 32'sd0);
    issue(OP_DUMP, 32'sd0);
    issue(OP_POP_FRONT, 32'sd0);
    issue(OP_POP_BACK, 32'sd0);
    issue(OP_DUMP, 32'sd0);
    wait_drained();

    filling = 1'b1;
    phase_left = $urandom_range(25, 45);
    for (int n = 0; n < 220; n++) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(25, 45);
        if ($urandom_range(0, 1) == 0) wait_drained();
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 35) op = OP_PUSH_BACK;
        else if (r < 70) op = OP_PUSH_FRONT;
        else if (r < 78) op = OP_POP_BACK;
        else if (r < 86) op = OP_POP_FRONT;
        else if (r < 96) op = OP_DUMP;
        else op = OpW'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
      end else begin
        if (r < 10) op = OP_PUSH_BACK;
        else if (r < 20) op = OP_PUSH_FRONT;
        else if (r < 50) op = OP_POP_BACK;
        else if (r < 80) op = OP_POP_FRONT;
        else if (r < 93) op = OP_DUMP;
        else op = OpW'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
      end
      case ($urandom_range(0, 9))
        0: val = 32'sh7fffffff;
        1: val = 32'sh80000000;
        default: val = $urandom;
      endcase
      issue(op, val);
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ bounded_deque_with_dump.f @@
+incdir+src
src/bdq_pkg.sv
src/bdq_ram.sv
src/bdq_ctrl.sv
src/bounded_deque_with_dump.sv
test/tb_bounded_deque_with_dump.sv
